>>> rtl/assert_macros.svh
// Assertion helpers; each check samples on clk_i and is off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define GZHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define GZHS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GZHS_ASSERT(lbl, prop, msg)

`define GZHS_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/gzhs_pkg.sv
package gzhs_pkg;

  localparam int WinDepth = 8;
  localparam int QueueDepth = 4;

  // header parse phases
  localparam logic [2:0] PH_HDR   = 3'd0;
  localparam logic [2:0] PH_XLO   = 3'd1;
  localparam logic [2:0] PH_XHI   = 3'd2;
  localparam logic [2:0] PH_XSKIP = 3'd3;
  localparam logic [2:0] PH_NAME  = 3'd4;
  localparam logic [2:0] PH_CMT   = 3'd5;
  localparam logic [2:0] PH_HCRC  = 3'd6;
  localparam logic [2:0] PH_DATA  = 3'd7;

  // FLG bit positions
  localparam int FlHcrc  = 1;
  localparam int FlExtra = 2;
  localparam int FlName  = 3;
  localparam int FlCmt   = 4;

  localparam logic [7:0] GZ_ID1 = 8'h1f;
  localparam logic [7:0] GZ_ID2 = 8'h8b;
  localparam logic [7:0] GZ_CM_DEFLATE = 8'h08;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [31:0] original_size;
    logic        run_last;
  } res_t;

  typedef struct packed {
    logic push0;
    logic push1;
    res_t r0;
    res_t r1;
  } push_t;

  typedef struct packed {
    logic [2:0] level;
    logic       room2;
  } qstat_t;

  // first enabled optional stage at or after 'from'
  function automatic logic [2:0] next_stage(logic [2:0] from, logic [4:0] fl);
    logic [2:0] ph;
    if (from <= PH_XLO && fl[FlExtra]) ph = PH_XLO;
    else if (from <= PH_NAME && fl[FlName]) ph = PH_NAME;
    else if (from <= PH_CMT && fl[FlCmt]) ph = PH_CMT;
    else if (from <= PH_HCRC && fl[FlHcrc]) ph = PH_HCRC;
    else ph = PH_DATA;
    return ph;
  endfunction

endpackage

>>> rtl/gzip_header_stripper_unit.sv
// channel  dir  fields (tdata low bit up)                          tuser  tlast
// s_axis   in   in_byte[7:0]                                       -      end_of_source
// m_axis   out  payload_byte[7:0] status[9:8] original_size[41:10] kind   run_last
//
// One input item per cycle; the parser updates its state in the accept cycle and
// pushes up to two results into a four-entry output queue.
// An item whose byte is payload and which ends the member yields two results, the
// payload and then the end report; every other item sustains one per cycle.
// s_axis_tready drops while the queue has room for fewer than two results.
// Reset is asynchronous, active low; it clears parser control state and the queue.
`include "assert_macros.svh"

module gzip_header_stripper_unit import gzhs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,   // end_of_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // payload_byte, status, original_size, zero fill
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast    // run_last
);

  logic   in_acc;
  logic   out_acc;
  push_t  push;
  res_t   head;
  qstat_t qstat;

  assign s_axis_tready = qstat.room2;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  gzhs_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_acc),
    .in_byte_i (s_axis_tdata),
    .last_i    (s_axis_tlast),
    .push_o    (push)
  );

  gzhs_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .stat_o  (qstat)
  );

  gzhs_out_fmt u_fmt (
    .res_i   (head),
    .tdata_o (m_axis_tdata),
    .tuser_o (m_axis_tuser),
    .tlast_o (m_axis_tlast)
  );

  `GZHS_ASSERT(a_level_bound, qstat.level <= 3'd4, "output queue overfilled")
  `GZHS_ASSERT_IMPL(a_end_reported, in_acc && s_axis_tlast, m_axis_tvalid, "end report missing")
  `GZHS_ASSERT(a_end_is_last, !(out_acc && m_axis_tuser) || m_axis_tlast, "end report not last")

endmodule

>>> rtl/gzhs_parser.sv
module gzhs_parser import gzhs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       last_i,
  output push_t      push_o
);

  logic [7:0]  win_q [WinDepth];
  logic [7:0]  win_d [WinDepth];
  logic [3:0]  fill_q, fill_d, fill_n;
  logic [2:0]  phase_q, phase_d, phase_n;
  logic [15:0] cnt_q, cnt_d, cnt_n;
  logic [4:0]  flags_q, flags_d, flags_n;
  logic        err_q, err_d, err_n;

  logic        full;
  logic [7:0]  leaving;
  logic        pay;
  logic        bad;
  logic [15:0] xlen;
  logic [15:0] dec;
  logic [1:0]  st;
  res_t        pay_res, end_res;

  assign full = fill_q[3];
  assign leaving = win_q[0];

  always_comb begin
    for (int i = 0; i < WinDepth - 1; i++) win_d[i] = win_q[i + 1];
    win_d[WinDepth - 1] = in_byte_i;

    phase_n = phase_q;
    cnt_n   = cnt_q;
    flags_n = flags_q;
    err_n   = err_q;
    pay     = 1'b0;
    bad     = 1'b0;
    xlen    = {leaving, cnt_q[7:0]};
    dec     = cnt_q - 16'd1;

    if (full && !err_q) begin
      case (phase_q)
        PH_HDR: begin
          bad = (cnt_q == 16'd0 && leaving != GZ_ID1) ||
                (cnt_q == 16'd1 && leaving != GZ_ID2) ||
                (cnt_q == 16'd2 && leaving != GZ_CM_DEFLATE) ||
                (cnt_q == 16'd3 && leaving[7:5] != 3'd0);
          if (cnt_q == 16'd3) flags_n = leaving[4:0];
          if (bad) begin
            err_n = 1'b1;
          end else if (cnt_q >= 16'd9) begin
            phase_n = next_stage(PH_XLO, flags_q);
            cnt_n   = '0;
          end else begin
            cnt_n = cnt_q + 16'd1;
          end
        end
        PH_XLO: begin
          cnt_n   = {8'd0, leaving};
          phase_n = PH_XHI;
        end
        PH_XHI: begin
          if (xlen == 16'd0) begin
            phase_n = next_stage(PH_NAME, flags_q);
            cnt_n   = '0;
          end else begin
            phase_n = PH_XSKIP;
            cnt_n   = xlen;
          end
        end
        PH_XSKIP: begin
          cnt_n = dec;
          if (dec == 16'd0) phase_n = next_stage(PH_NAME, flags_q);
        end
        PH_NAME: begin
          if (leaving == 8'd0) begin
            phase_n = next_stage(PH_CMT, flags_q);
            cnt_n   = '0;
          end
        end
        PH_CMT: begin
          if (leaving == 8'd0) begin
            phase_n = next_stage(PH_HCRC, flags_q);
            cnt_n   = '0;
          end
        end
        PH_HCRC: begin
          if (cnt_q >= 16'd1) begin
            phase_n = next_stage(PH_DATA, flags_q);
            cnt_n   = '0;
          end else begin
            cnt_n = cnt_q + 16'd1;
          end
        end
        PH_DATA: pay = 1'b1;
        default: pay = 1'b0;
      endcase
    end

    fill_n = full ? fill_q : fill_q + 4'd1;

    if (err_n) st = ST_BAD;
    else if (phase_n != PH_DATA || !fill_n[3]) st = ST_SHORT;
    else st = ST_OK;

    pay_res.kind          = KIND_PAYLOAD;
    pay_res.payload_byte  = leaving;
    pay_res.status        = ST_OK;
    pay_res.original_size = '0;
    pay_res.run_last      = !last_i;

    end_res.kind          = KIND_END;
    end_res.payload_byte  = '0;
    end_res.status        = st;
    end_res.original_size = (st == ST_OK) ? {win_d[7], win_d[6], win_d[5], win_d[4]} : '0;
    end_res.run_last      = 1'b1;

    // end of member: all control state back to reset for the next one
    if (last_i) begin
      fill_d  = '0;
      phase_d = PH_HDR;
      cnt_d   = '0;
      flags_d = '0;
      err_d   = 1'b0;
    end else begin
      fill_d  = fill_n;
      phase_d = phase_n;
      cnt_d   = cnt_n;
      flags_d = flags_n;
      err_d   = err_n;
    end

    push_o.push0 = accept_i && (pay || last_i);
    push_o.push1 = accept_i && pay && last_i;
    push_o.r0    = pay ? pay_res : end_res;
    push_o.r1    = end_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      phase_q <= PH_HDR;
      cnt_q   <= '0;
      flags_q <= '0;
      err_q   <= 1'b0;
    end else if (accept_i) begin
      fill_q  <= fill_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      flags_q <= flags_d;
      err_q   <= err_d;
    end
  end

  // window taps carry no reset
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int i = 0; i < WinDepth; i++) win_q[i] <= win_d[i];
    end
  end

endmodule

>>> rtl/gzhs_out_queue.sv
module gzhs_out_queue import gzhs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  input  logic   pop_i,
  output res_t   head_o,
  output logic   valid_o,
  output qstat_t stat_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int LvlW = $clog2(QueueDepth + 1);

  res_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic [PtrW-1:0] wr_next;
  logic [LvlW-1:0] n_push;
  logic            do_pop;

  assign do_pop  = pop_i && (lvl_q != '0);
  assign wr_next = wr_q + PtrW'(1);
  assign n_push  = LvlW'(push_i.push0) + LvlW'(push_i.push1);

  always_comb begin
    wr_d  = wr_q + PtrW'(n_push);
    rd_d  = do_pop ? rd_q + PtrW'(1) : rd_q;
    lvl_d = lvl_q + n_push - LvlW'(do_pop);
  end

  assign head_o       = mem_q[rd_q];
  assign valid_o      = (lvl_q != '0);
  assign stat_o.level = lvl_q;
  // an item may bring two results, so accept only with room for both
  assign stat_o.room2 = (lvl_q <= LvlW'(QueueDepth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) mem_q[wr_q] <= push_i.r0;
    if (push_i.push1) mem_q[wr_next] <= push_i.r1;
  end

endmodule

>>> rtl/gzhs_out_queue_wrap_note.sv
module gzhs_out_fmt import gzhs_pkg::*; (
  input  res_t        res_i,
  output logic [47:0] tdata_o,
  output logic        tuser_o,
  output logic        tlast_o
);

  assign tdata_o = {6'd0, res_i.original_size, res_i.status, res_i.payload_byte};
  assign tuser_o = res_i.kind;
  assign tlast_o = res_i.run_last;

endmodule
